// File: design/b2s_pkg.sv
package b2s_pkg;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam int unsigned MAX_RESULTS = 3;

	typedef struct packed {
		logic [7:0] value;
		logic       run_last;
		logic       frame_last;
	} b2s_res_t;

	typedef struct packed {
		b2s_res_t [MAX_RESULTS-1:0] res;
		logic [1:0]                 count;
		logic [2:0]                 phase;
		logic [7:0]                 carry;
	} b2s_step_t;

endpackage

// File: design/b2s_step.sv
module b2s_step (
	input  logic              dir,
	input  logic [7:0]        data,
	input  logic              fend,
	input  logic [2:0]        phase,
	input  logic [7:0]        carry,
	output b2s_pkg::b2s_step_t step
);

	logic [6:0]  enc_ext;
	logic [7:0]  enc_carry;
	logic [7:0]  dec_d;
	logic [3:0]  dec_sh;
	logic [7:0]  dec_byte;
	logic [7:0]  dec_carry;
	logic [1:0]  k;
	logic [2:0]  new_phase;
	logic [7:0]  new_carry;

	// encode: shift byte up by phase and merge carry
	assign enc_ext   = 7'((data << phase) | carry);
	assign enc_carry = data >> (3'd7 - phase);

	// decode: bit 7 ignored
	assign dec_d     = {1'b0, data[6:0]};
	assign dec_sh    = 4'd8 - {1'b0, phase};
	assign dec_byte  = (dec_d << dec_sh) | carry;
	assign dec_carry = dec_d >> phase;

	always_comb begin
		step      = '0;
		k         = 2'd0;
		new_phase = phase;
		new_carry = carry;
		if (dir == b2s_pkg::DIR_ENCODE) begin
			step.res[0].value = {1'b0, enc_ext};
			k                 = 2'd1;
			new_carry         = enc_carry;
			if (phase == 3'd7) begin
				// second character straight from the carry
				step.res[1].value = {1'b0, enc_carry[6:0]};
				k                 = 2'd2;
				new_carry         = {7'b0, enc_carry[7]};
				new_phase         = 3'd1;
			end else begin
				new_phase = phase + 3'd1;
			end
		end else begin
			new_phase = phase + 3'd1;
			if (phase == 3'd0) begin
				new_carry = dec_d;
			end else begin
				step.res[0].value = dec_byte;
				k                 = 2'd1;
				new_carry         = dec_carry;
			end
		end
		if (fend) begin
			if (new_carry != 8'd0) begin
				step.res[k].value = new_carry;
				k                 = k + 2'd1;
			end
			new_phase = 3'd0;
			new_carry = 8'd0;
		end
		if (k != 2'd0) begin
			step.res[k - 2'd1].run_last   = 1'b1;
			step.res[k - 2'd1].frame_last = fend;
		end
		step.count = k;
		step.phase = new_phase;
		step.carry = new_carry;
	end

endmodule

// File: design/byte_to_seven_bit_codec.sv
// channel | direction | handshake              | payload
// s       | in        | s_tvalid / s_tready    | s_tdata = data_byte, s_tlast = frame_end
// m       | out       | m_tvalid / m_tready    | m_tdata = value, m_tuser = run_last,
//         |           |                        | m_tlast = frame_last
// cfg     | in        | cfg_valid / cfg_ready  | cfg_data = direction
//
// one transaction per cycle on s while each one yields at most one result and m_tready is high
// a transaction reaches its first result through the input register, then the result buffer
// a transaction with two or three results holds s until all but its last result are taken on m
// m stalls back up through the result buffer and input register to s_tready
// arst_n clears phase, carry, direction and all valid state
module byte_to_seven_bit_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] value
	output logic       m_tuser,  // [0] run_last
	output logic       m_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);

	logic [7:0] data_s1;
	logic       fend_s1;
	logic       valid_s1;
	logic       dir_q;
	logic [2:0] phase_q;
	logic [7:0] carry_q;
	logic [1:0] cnt_q;
	logic       pop;
	logic       load;
	logic       bank_free;

	b2s_pkg::b2s_res_t [b2s_pkg::MAX_RESULTS-1:0] res_q;
	b2s_pkg::b2s_step_t                           step;

	b2s_step u_step (
		.dir   (dir_q),
		.data  (data_s1),
		.fend  (fend_s1),
		.phase (phase_q),
		.carry (carry_q),
		.step  (step)
	);

	assign pop       = m_tvalid && m_tready;
	assign bank_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_tready);
	assign load      = valid_s1 && bank_free;
	assign s_tready  = !valid_s1 || load;
	assign cfg_ready = !valid_s1;

	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = res_q[0].value;
	assign m_tuser  = res_q[0].run_last;
	assign m_tlast  = res_q[0].frame_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			fend_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= b2s_pkg::DIR_ENCODE;
		end else if (cfg_valid && cfg_ready) begin
			dir_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 3'd0;
			carry_q <= 8'd0;
		end else if (load) begin
			phase_q <= step.phase;
			carry_q <= step.carry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= step.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// result buffer drains from entry 0
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= step.res;
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	a_frame_implies_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("frame_last without run_last");

	a_frame_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		load && fend_s1 |=> (phase_q == 3'd0) && (carry_q == 8'd0))
		else $error("state not cleared after frame end");

	a_encode_emits: assert property (@(posedge clk) disable iff (!arst_n)
		load && (dir_q == b2s_pkg::DIR_ENCODE) |-> step.count != 2'd0)
		else $error("encode transaction produced no result");

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (cnt_q == 2'd1) |-> m_tuser)
		else $error("final buffered result lacks run_last");

endmodule
